/* hw/rtl/ltr_pkg.sv */
`timescale 1ns / 1ps

package ltr_pkg;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Line ending kinds, also used for the remembered first style
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CR   = 2'd1;
    localparam logic [1:0] KIND_LF   = 2'd2;
    localparam logic [1:0] KIND_CRLF = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_EOL_LEN    = 2'd0;
    localparam logic [1:0] REG_EOL_FIRST  = 2'd1;
    localparam logic [1:0] REG_EOL_SECOND = 2'd2;
    localparam logic [1:0] REG_REPAIR     = 2'd3;

    localparam int MAX_WORDS = 3;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] eol_len;
        logic [7:0] eol_first;
        logic [7:0] eol_second;
        logic       repair;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
    } word_t;

    // All result words caused by one accepted input byte
    typedef struct packed {
        logic [1:0]                 cnt;
        word_t [MAX_WORDS-1:0]      w;
    } job_t;

    typedef struct packed {
        logic halted;
        logic raise;
    } front_stat_t;

endpackage

/* hw/rtl/ltr_front.sv */
`timescale 1ns / 1ps

module ltr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_stream,
    input  ltr_pkg::cfg_t        cfg,
    output ltr_pkg::job_t        job,
    output logic                 job_push,
    output ltr_pkg::front_stat_t stat
);

    logic [1:0] pending_reg, pending_next;
    logic [1:0] first_reg, first_next;
    logic       halted_reg;

    logic       is_nl;
    logic [1:0] kind_in;
    logic [1:0] ekind;
    logic       have_end;
    logic       tail_data;
    logic       tail_done;
    logic       style_ok;
    logic [1:0] n;
    ltr_pkg::job_t job_ok;

    assign is_nl   = (in_byte == ltr_pkg::BYTE_CR) || (in_byte == ltr_pkg::BYTE_LF);
    assign kind_in = (in_byte == ltr_pkg::BYTE_CR) ? ltr_pkg::KIND_CR : ltr_pkg::KIND_LF;

    // Classify: which ending (if any) to write, what follows it, next pending
    always_comb
    begin
        have_end     = 1'b0;
        ekind        = pending_reg;
        tail_data    = 1'b0;
        tail_done    = 1'b0;
        pending_next = pending_reg;
        if (end_of_stream)
        begin
            have_end     = (pending_reg != ltr_pkg::KIND_NONE);
            tail_done    = 1'b1;
            pending_next = ltr_pkg::KIND_NONE;
        end
        else if (is_nl && (cfg.eol_len != 2'd0))
        begin
            if (pending_reg == ltr_pkg::KIND_NONE)
            begin
                pending_next = kind_in;
            end
            else if ((pending_reg == kind_in) ||
                     ((pending_reg == ltr_pkg::KIND_LF) && (kind_in == ltr_pkg::KIND_CR)))
            begin
                have_end     = 1'b1;
                pending_next = kind_in;
            end
            else
            begin
                have_end     = 1'b1;
                ekind        = ltr_pkg::KIND_CRLF;
                pending_next = ltr_pkg::KIND_NONE;
            end
        end
        else
        begin
            have_end     = (pending_reg != ltr_pkg::KIND_NONE);
            tail_data    = 1'b1;
            pending_next = ltr_pkg::KIND_NONE;
        end
    end

    assign style_ok = !have_end || (first_reg == ltr_pkg::KIND_NONE) || cfg.repair ||
                      (first_reg == ekind);

    always_comb
    begin
        if (end_of_stream)
            first_next = ltr_pkg::KIND_NONE;
        else if (have_end && (first_reg == ltr_pkg::KIND_NONE))
            first_next = ekind;
        else
            first_next = first_reg;
    end

    // Assemble the result words
    always_comb
    begin
        job_ok = '0;
        n      = 2'd0;
        if (have_end)
        begin
            unique case (cfg.eol_len)
                2'd0:
                begin
                    job_ok.w[0].data = (ekind == ltr_pkg::KIND_CR) ? ltr_pkg::BYTE_CR
                                                                   : ltr_pkg::BYTE_LF;
                    n = 2'd1;
                end
                2'd1:
                begin
                    job_ok.w[0].data = cfg.eol_first;
                    n = 2'd1;
                end
                default:
                begin
                    job_ok.w[0].data = cfg.eol_first;
                    job_ok.w[1].data = cfg.eol_second;
                    n = 2'd2;
                end
            endcase
        end
        if (tail_data)
        begin
            job_ok.w[n].data   = in_byte;
            job_ok.w[n].status = ltr_pkg::ST_DATA;
            n = n + 2'd1;
        end
        else if (tail_done)
        begin
            job_ok.w[n].status = ltr_pkg::ST_DONE;
            n = n + 2'd1;
        end
        job_ok.cnt = n;
    end

    always_comb
    begin
        job = job_ok;
        if (!style_ok)
        begin
            job           = '0;
            job.cnt       = 2'd1;
            job.w[0].status = ltr_pkg::ST_ERROR;
        end
    end

    assign job_push    = item_valid && !halted_reg && (job.cnt != 2'd0);
    assign stat.halted = halted_reg;
    assign stat.raise  = item_valid && !halted_reg && !style_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= ltr_pkg::KIND_NONE;
            first_reg   <= ltr_pkg::KIND_NONE;
            halted_reg  <= 1'b0;
        end
        else if (item_valid && !halted_reg)
        begin
            if (!style_ok)
            begin
                halted_reg <= 1'b1;
            end
            else
            begin
                pending_reg <= pending_next;
                first_reg   <= first_next;
            end
        end
    end

endmodule

/* hw/rtl/ltr_fifo.sv */
`timescale 1ns / 1ps

module ltr_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ltr_pkg::job_t push_job,
    input  logic          pop,
    output ltr_pkg::job_t head,
    output logic          not_empty,
    output logic          full
);

    ltr_pkg::job_t mem_reg [ltr_pkg::QDEPTH];
    logic [ltr_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ltr_pkg::QCNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == ltr_pkg::QCNT_W'(ltr_pkg::QDEPTH));
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    function automatic logic [ltr_pkg::QPTR_W-1:0] bump(input logic [ltr_pkg::QPTR_W-1:0] p);
        if (p == ltr_pkg::QPTR_W'(ltr_pkg::QDEPTH - 1))
            bump = '0;
        else
            bump = p + ltr_pkg::QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + ltr_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - ltr_pkg::QCNT_W'(1);
        end
    end

endmodule

/* hw/rtl/ltr_back.sv */
`timescale 1ns / 1ps

module ltr_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  ltr_pkg::job_t head,
    input  logic          head_valid,
    output logic          head_pop,
    input  logic          pop,
    output logic          out_valid,
    output ltr_pkg::word_t out_word,
    output logic          out_last
);

    logic [1:0]     idx_reg;
    logic           vld_reg;
    ltr_pkg::word_t word_reg;
    logic           last_reg;
    logic           load;
    logic           final_word;

    assign load       = head_valid && (!vld_reg || pop);
    assign final_word = (idx_reg == (head.cnt - 2'd1));
    assign head_pop   = load && final_word;

    assign out_valid = vld_reg;
    assign out_word  = word_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= head.w[idx_reg];
            last_reg <= final_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                vld_reg <= 1'b1;
                idx_reg <= final_word ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/line_ending_translator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Word
// input     in         push / full      in_byte, end_of_stream
// result    out        pop / empty      out_byte, status, last
// config    in/out     APB write/read   eol_len @0, eol_first @4, eol_second @8, repair @12
//
// One input byte is accepted per cycle while full is low and classified in the same
// cycle; its zero to three result words are queued as one entry (none when it only
// starts holding an ending or the block is halted). The first word passes through the queue
// and then the output register; words then follow one per cycle while pop is high or the
// output is empty, and a two-entry queue absorbs bytes that expand to more than one word.
// Reset clears pending ending, style, halt, queue and output; full needs both entries.

module line_ending_translator
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_stream,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [1:0]  status,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ltr_pkg::cfg_t        cfg_reg;
    ltr_pkg::job_t        front_job;
    ltr_pkg::job_t        q_head;
    ltr_pkg::front_stat_t front_stat;
    ltr_pkg::word_t       res_word;
    logic                 front_push;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 q_pop;
    logic                 res_valid;
    logic                 item_valid;
    logic                 cfg_wr;

    // Register file: decode on the word address only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eol_len    <= 2'd1;
            cfg_reg.eol_first  <= 8'd10;
            cfg_reg.eol_second <= 8'd0;
            cfg_reg.repair     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                ltr_pkg::REG_EOL_LEN:    cfg_reg.eol_len    <= pwdata[1:0];
                ltr_pkg::REG_EOL_FIRST:  cfg_reg.eol_first  <= pwdata[7:0];
                ltr_pkg::REG_EOL_SECOND: cfg_reg.eol_second <= pwdata[7:0];
                ltr_pkg::REG_REPAIR:     cfg_reg.repair     <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ltr_pkg::REG_EOL_LEN:    prdata = {30'd0, cfg_reg.eol_len};
            ltr_pkg::REG_EOL_FIRST:  prdata = {24'd0, cfg_reg.eol_first};
            ltr_pkg::REG_EOL_SECOND: prdata = {24'd0, cfg_reg.eol_second};
            ltr_pkg::REG_REPAIR:     prdata = {31'd0, cfg_reg.repair};
        endcase
    end

    // Front: accept and classify, hold the pending ending and first style
    assign full       = q_full;
    assign item_valid = push && !q_full;

    ltr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .cfg           (cfg_reg),
        .job           (front_job),
        .job_push      (front_push),
        .stat          (front_stat)
    );

    // Queue of per-byte result groups between the two sides
    ltr_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_job  (front_job),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Back: walk the group one word per cycle, while the output is popped or empty, into the output register
    ltr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_not_empty),
        .head_pop   (q_pop),
        .pop        (pop),
        .out_valid  (res_valid),
        .out_word   (res_word),
        .out_last   (last)
    );

    assign empty    = !res_valid;
    assign out_byte = res_word.data;
    assign status   = res_word.status;

`ifndef SYNTHESIS
    // An error halts the front from the next cycle on
    a_raise_halts: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.raise |=> front_stat.halted)
        else $error("error raised without halting");

    // Halt holds until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.halted |=> front_stat.halted)
        else $error("halt released without reset");

    // Error and done words end their group with a zero byte; an error word stands alone
    a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ltr_pkg::ST_DATA)) |-> (last && (out_byte == 8'd0)))
        else $error("non-data word malformed");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_push |-> !q_full)
        else $error("queue overflow");
`endif

endmodule
